// ===== design/crng_pkg.sv =====
// Shared constants, types and handshake structs for the combined LCG shuffle generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package crng_pkg;

    localparam int DATA_W          = 31;
    localparam int TABLE_DEPTH_DEF = 32;

    // Generator moduli, multipliers and Schrage quotients/remainders
    localparam longint MOD_A = 64'd2147483563;
    localparam longint MOD_B = 64'd2147483399;
    localparam longint MUL_A = 64'd40014;
    localparam longint MUL_B = 64'd40692;
    localparam longint QUO_A = 64'd53668;
    localparam longint QUO_B = 64'd52774;
    localparam longint REM_A = 64'd12211;
    localparam longint REM_B = 64'd3791;

    localparam longint WRAP_TOP = MOD_A - 64'd1;

    // Reciprocal division: quotient = (x * REC) >> RECIP_SH, then one correction
    localparam int     RECIP_SH = 47;
    localparam longint REC_A    = (64'd1 << RECIP_SH) / QUO_A;
    localparam longint REC_B    = (64'd1 << RECIP_SH) / QUO_B;

    localparam int K_W   = 64 - RECIP_SH;
    localparam int MUL_W = 16;
    localparam int REM_W = 14;

    typedef enum logic [1:0] {
        OP_STEP_A = 2'd0,
        OP_STEP_B = 2'd1,
        OP_SLOT   = 2'd2
    } op_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic [DATA_W-1:0] z;
    } arith_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } arith_rsp_t;

endpackage

`default_nettype wire

// ===== design/crng_arith.sv =====
// Shared multiply unit with a small sequencer: Schrage steps for both generators
// and the table slot division. Depends on crng_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crng_arith #(
    parameter int TABLE_DEPTH = crng_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire crng_pkg::arith_req_t req,
    output crng_pkg::arith_rsp_t      rsp
);
    import crng_pkg::*;

    localparam longint SLOT_DIV = 64'd1 + WRAP_TOP / longint'(TABLE_DEPTH);
    localparam longint SLOT_REC = (64'd1 << RECIP_SH) / SLOT_DIV;
    localparam logic [K_W-1:0] SLOT_MAX = K_W'(TABLE_DEPTH - 1);

    typedef enum logic [6:0] {
        AR_IDLE  = 7'b0000001,
        AR_RECIP = 7'b0000010,
        AR_KQ    = 7'b0000100,
        AR_FIX   = 7'b0001000,
        AR_MR    = 7'b0010000,
        AR_KR    = 7'b0100000,
        AR_SUB   = 7'b1000000
    } ar_state_t;

    ar_state_t          state_reg;
    op_t                op_reg;
    logic [DATA_W-1:0]  z_reg;
    logic [63:0]        prod_reg;
    logic [K_W-1:0]     k_reg;
    logic [31:0]        r_reg;
    logic [31:0]        mr_reg;
    logic               done_reg;
    logic [DATA_W-1:0]  result_reg;

    logic [31:0]        rec_c;
    logic [31:0]        div_c;
    logic [MUL_W-1:0]   mul_c;
    logic [REM_W-1:0]   rem_c;
    logic [DATA_W-1:0]  mod_c;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [31:0]        r0;
    logic               r_over;
    logic [K_W-1:0]     k_fix;
    logic [K_W-1:0]     k_sat;
    logic [32:0]        t_raw;
    logic [32:0]        t_fix;

    always_comb
    begin
        case (op_reg)
            OP_STEP_A:
            begin
                rec_c = 32'(REC_A);
                div_c = 32'(QUO_A);
                mul_c = MUL_W'(MUL_A);
                rem_c = REM_W'(REM_A);
                mod_c = DATA_W'(MOD_A);
            end
            OP_STEP_B:
            begin
                rec_c = 32'(REC_B);
                div_c = 32'(QUO_B);
                mul_c = MUL_W'(MUL_B);
                rem_c = REM_W'(REM_B);
                mod_c = DATA_W'(MOD_B);
            end
            default:
            begin
                rec_c = 32'(SLOT_REC);
                div_c = 32'(SLOT_DIV);
                mul_c = '0;
                rem_c = '0;
                mod_c = '0;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            AR_RECIP:
            begin
                mul_a = {1'b0, z_reg};
                mul_b = rec_c;
            end
            AR_KQ:
            begin
                mul_a = 32'(prod_reg[63:RECIP_SH]);
                mul_b = div_c;
            end
            AR_MR:
            begin
                mul_a = r_reg;
                mul_b = 32'(mul_c);
            end
            AR_KR:
            begin
                mul_a = 32'(k_reg);
                mul_b = 32'(rem_c);
            end
            default:
            begin
            end
        endcase
    end

    assign r0     = {1'b0, z_reg} - prod_reg[31:0];
    assign r_over = (r0 >= div_c);
    assign k_fix  = r_over ? k_reg + K_W'(1) : k_reg;
    assign k_sat  = (k_fix > SLOT_MAX) ? SLOT_MAX : k_fix;
    assign t_raw  = {1'b0, mr_reg} - {1'b0, prod_reg[31:0]};
    assign t_fix  = t_raw[32] ? t_raw + {2'b00, mod_c} : t_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                AR_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= AR_RECIP;
                    end
                end
                AR_RECIP: state_reg <= AR_KQ;
                AR_KQ:    state_reg <= AR_FIX;
                AR_FIX:
                begin
                    if (op_reg == OP_SLOT)
                    begin
                        state_reg <= AR_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= AR_MR;
                    end
                end
                AR_MR:    state_reg <= AR_KR;
                AR_KR:    state_reg <= AR_SUB;
                AR_SUB:
                begin
                    state_reg <= AR_IDLE;
                    done_reg  <= 1'b1;
                end
                default:  state_reg <= AR_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == AR_IDLE && req.start)
        begin
            op_reg <= req.op;
            z_reg  <= req.z;
        end
        if (state_reg == AR_KQ)
        begin
            k_reg <= prod_reg[63:RECIP_SH];
        end
        if (state_reg == AR_FIX)
        begin
            k_reg      <= k_fix;
            r_reg      <= r_over ? r0 - div_c : r0;
            result_reg <= DATA_W'(k_sat);
        end
        if (state_reg == AR_KR)
        begin
            mr_reg <= prod_reg[31:0];
        end
        if (state_reg == AR_SUB)
        begin
            result_reg <= t_fix[DATA_W-1:0];
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

// ===== design/crng_table.sv =====
// Shuffle table storage: one write port, one registered read port.
// Depends on crng_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crng_table #(
    parameter int TABLE_DEPTH = crng_pkg::TABLE_DEPTH_DEF,
    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [SLOT_W-1:0]           wr_addr,
    input  wire logic [crng_pkg::DATA_W-1:0] wr_data,
    input  wire logic [SLOT_W-1:0]           rd_addr,
    output logic      [crng_pkg::DATA_W-1:0] rd_data
);
    import crng_pkg::*;

    logic [DATA_W-1:0] mem [TABLE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/combined_lcg_shuffle_rng_core.sv =====
// Combined LCG generator with shuffle table: sequencer, state and output register.
// Uses crng_pkg, crng_arith and crng_table.
//
// Usage: one input beat (mode, seed) yields one output beat (value). mode 0 draws the
// next value; mode 1 loads seed (zero taken as one), rebuilds the shuffle table and
// then draws. The uniform deviate is value / 2147483563.
// Sequence: a draw runs one slot division and then two generator steps (one, then two)
// on the single shared 32x32 multiplier, and combines the result in ST_OUT. A reseed,
// and the first beat after reset, first adds TABLE_DEPTH+8 warm-up steps of generator one.
// Flow: one beat at a time; in_ready is high only while the sequencer is idle, so the
// next draw is accepted only after the previous one has left ST_OUT.
// The finished value sits in an output register, so a new beat is accepted while it
// waits; if the receiver still stalls when the next value is done, the sequencer
// holds it until out_ready.
// Reset: generator one returns to 1 and the table is marked for rebuild; no clearing
// pass is needed, the first beat refills every table entry before any read.
`timescale 1ns / 1ps
`default_nettype none

module combined_lcg_shuffle_rng_core #(
    parameter int TABLE_DEPTH = crng_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [crng_pkg::DATA_W-1:0] seed,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [crng_pkg::DATA_W-1:0] value
);
    import crng_pkg::*;

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 8);
    localparam logic [CNT_W-1:0] INIT_LAST  = CNT_W'(TABLE_DEPTH + 7);
    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(TABLE_DEPTH);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_INIT_GO   = 10'b0000000010,
        ST_INIT_WAIT = 10'b0000000100,
        ST_SLOT_GO   = 10'b0000001000,
        ST_SLOT_WAIT = 10'b0000010000,
        ST_A_GO      = 10'b0000100000,
        ST_A_WAIT    = 10'b0001000000,
        ST_B_GO      = 10'b0010000000,
        ST_B_WAIT    = 10'b0100000000,
        ST_OUT       = 10'b1000000000
    } state_t;

    state_t             state_reg;
    logic [DATA_W-1:0]  gen_one_reg;
    logic [DATA_W-1:0]  gen_two_reg;
    logic [DATA_W-1:0]  last_reg;
    logic               needs_init_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               out_valid_reg;
    logic [DATA_W-1:0]  value_reg;

    arith_req_t         arith_req;
    arith_rsp_t         arith_rsp;

    logic               tbl_wr_en;
    logic [SLOT_W-1:0]  tbl_wr_addr;
    logic [DATA_W-1:0]  tbl_wr_data;
    logic [DATA_W-1:0]  tbl_rd_data;

    logic               accept;
    logic               start_init;
    logic [DATA_W-1:0]  seed_fix;
    logic               out_load;
    logic               init_done;
    logic [32:0]        diff;
    logic [32:0]        mix;
    logic [DATA_W-1:0]  draw_value;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign start_init = mode || needs_init_reg;
    assign seed_fix   = (seed == '0) ? DATA_W'(1) : seed;
    assign out_load   = !out_valid_reg || out_ready;
    assign init_done  = (state_reg == ST_INIT_WAIT) && arith_rsp.done;

    assign diff       = {2'b00, tbl_rd_data} - {2'b00, gen_two_reg};
    assign mix        = (diff[32] || diff == '0) ? diff + 33'(WRAP_TOP) : diff;
    assign draw_value = mix[DATA_W-1:0];

    always_comb
    begin
        arith_req.start = 1'b0;
        arith_req.op    = OP_SLOT;
        arith_req.z     = last_reg;
        unique case (state_reg)
            ST_INIT_GO:
            begin
                arith_req.start = 1'b1;
                arith_req.op    = OP_STEP_A;
                arith_req.z     = gen_one_reg;
            end
            ST_SLOT_GO:
            begin
                arith_req.start = 1'b1;
            end
            ST_A_GO:
            begin
                arith_req.start = 1'b1;
                arith_req.op    = OP_STEP_A;
                arith_req.z     = gen_one_reg;
            end
            ST_B_GO:
            begin
                arith_req.start = 1'b1;
                arith_req.op    = OP_STEP_B;
                arith_req.z     = gen_two_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_OUT)
        begin
            tbl_wr_en   = out_load;
            tbl_wr_addr = slot_reg;
            tbl_wr_data = gen_one_reg;
        end
        else
        begin
            tbl_wr_en   = init_done && (cnt_reg < DEPTH_CNT);
            tbl_wr_addr = cnt_reg[SLOT_W-1:0];
            tbl_wr_data = arith_rsp.result;
        end
    end

    crng_arith #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .rsp   (arith_rsp)
    );

    crng_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (slot_reg),
        .rd_data (tbl_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gen_one_reg    <= DATA_W'(1);
            needs_init_reg <= 1'b1;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg <= INIT_LAST;
                        if (mode)
                        begin
                            gen_one_reg <= seed_fix;
                        end
                        state_reg <= start_init ? ST_INIT_GO : ST_SLOT_GO;
                    end
                end
                ST_INIT_GO: state_reg <= ST_INIT_WAIT;
                ST_INIT_WAIT:
                begin
                    if (arith_rsp.done)
                    begin
                        gen_one_reg <= arith_rsp.result;
                        if (cnt_reg == '0)
                        begin
                            needs_init_reg <= 1'b0;
                            state_reg      <= ST_SLOT_GO;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg - CNT_W'(1);
                            state_reg <= ST_INIT_GO;
                        end
                    end
                end
                ST_SLOT_GO: state_reg <= ST_SLOT_WAIT;
                ST_SLOT_WAIT:
                begin
                    if (arith_rsp.done)
                    begin
                        state_reg <= ST_A_GO;
                    end
                end
                ST_A_GO: state_reg <= ST_A_WAIT;
                ST_A_WAIT:
                begin
                    if (arith_rsp.done)
                    begin
                        gen_one_reg <= arith_rsp.result;
                        state_reg   <= ST_B_GO;
                    end
                end
                ST_B_GO: state_reg <= ST_B_WAIT;
                ST_B_WAIT:
                begin
                    if (arith_rsp.done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && start_init)
        begin
            gen_two_reg <= mode ? seed_fix : gen_one_reg;
        end
        if (state_reg == ST_B_WAIT && arith_rsp.done)
        begin
            gen_two_reg <= arith_rsp.result;
        end
        if (init_done && cnt_reg == '0)
        begin
            last_reg <= arith_rsp.result;
        end
        if (state_reg == ST_SLOT_WAIT && arith_rsp.done)
        begin
            slot_reg <= arith_rsp.result[SLOT_W-1:0];
        end
        if (state_reg == ST_OUT && out_load)
        begin
            last_reg  <= draw_value;
            value_reg <= draw_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire

// ===== design/crng_checker.sv =====
// Port-level checker for combined_lcg_shuffle_rng_core, attached by bind.
// Depends on crng_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crng_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [crng_pkg::DATA_W-1:0] value
);
    import crng_pkg::*;

    localparam logic [DATA_W-1:0] VALUE_MAX = DATA_W'(WRAP_TOP);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("output beat changed while stalled");

    // drop ready after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");

    a_value_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> value != '0)
        else $error("value below range");

    a_value_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> value <= VALUE_MAX)
        else $error("value above range");

endmodule

bind combined_lcg_shuffle_rng_core crng_checker u_crng_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
);

`default_nettype wire
